@@ rtl/mkd_pkg.sv @@
// Shared types, constants and code tables for the Morse key decoder.
`default_nettype none

package mkd_pkg;

  localparam int DEF_MAX_SYMBOLS = 8;
  localparam int DEF_COUNT_WIDTH = 16;

  localparam int DOT_W      = 12;
  localparam int KIND_W     = 3;
  localparam int LETTER_W   = 6;
  localparam int SCOUNT_W   = 4;
  localparam int CFG_IDX_W  = 1;
  localparam int CHAR_COUNT = 36;

  localparam logic [DOT_W-1:0] DOT_RESET       = 12'd200;
  localparam logic [DOT_W-1:0] MIN_PRESS_RESET = 12'd30;

  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_DOT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_PRESS   = 1'b1;

  typedef enum logic [KIND_W-1:0] {
    EV_DOT     = 3'd0,
    EV_DASH    = 3'd1,
    EV_LETTER  = 3'd2,
    EV_UNKNOWN = 3'd3,
    EV_SPACE   = 3'd4
  } ev_kind_t;

  typedef struct packed {
    logic                hit;
    logic [LETTER_W-1:0] index;
  } mkd_match_t;

  // Symbol count of each character, A to Z then 0 to 9.
  localparam logic [2:0] CODE_LEN [CHAR_COUNT] = '{
    3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3, 3'd4, 3'd2, 3'd4, 3'd3, 3'd4, 3'd2,
    3'd2, 3'd3, 3'd4, 3'd4, 3'd3, 3'd3, 3'd1, 3'd3, 3'd4, 3'd3, 3'd4, 3'd4, 3'd4,
    3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5
  };

  // Bit i is symbol i of the character, a one being a dash.
  localparam logic [4:0] CODE_BITS [CHAR_COUNT] = '{
    5'h02, 5'h01, 5'h05, 5'h01, 5'h00, 5'h04, 5'h03, 5'h00, 5'h00, 5'h0E, 5'h05,
    5'h02, 5'h03, 5'h01, 5'h07, 5'h06, 5'h0B, 5'h02, 5'h00, 5'h01, 5'h04, 5'h08,
    5'h06, 5'h09, 5'h0D, 5'h03, 5'h1F, 5'h1E, 5'h1C, 5'h18, 5'h10, 5'h00, 5'h01,
    5'h03, 5'h07, 5'h0F
  };

endpackage

`default_nettype wire

@@ rtl/mkd_letter_match.sv @@
// Matches the buffered symbols of one letter against the character table.
`default_nettype none

module mkd_letter_match
  import mkd_pkg::*;
#(
  parameter int MAX_SYMBOLS = DEF_MAX_SYMBOLS
) (
  input  wire logic [MAX_SYMBOLS-1:0] pattern,
  input  wire logic [SCOUNT_W-1:0]    symbol_count,
  input  wire logic                   overflowed,
  output mkd_match_t                  result
);

  always_comb begin
    result = '0;
    // Codes are unique, so at most one entry can hit.
    for (int i = CHAR_COUNT - 1; i >= 0; i--) begin
      if (!overflowed
          && symbol_count == SCOUNT_W'(CODE_LEN[i])
          && pattern == MAX_SYMBOLS'(CODE_BITS[i])) begin
        result.hit   = 1'b1;
        result.index = LETTER_W'(i);
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/morse_key_decoder_core.sv @@
// Morse key decoder: times button presses and gaps and emits symbols and letters.
//
// The input channel takes one button level word per timebase tick
// (in_valid/in_ready, in_button_down). The result channel gives at most one
// word per tick: a dot, a dash, a decoded letter, an unknown code or a word
// space, each with the dot estimate in force after that tick.
// A word accepted at a clock edge is held in an input register, processed
// once the output register can advance, and its result, if any, is shown on
// out_* from then on. One word is accepted in every cycle while the receiver
// does not stall; the counters, dot multiples and the table match are all
// updated together, which sets that rate.
// While the receiver stalls, the result stays in the output register and the
// input register still takes one more word; in_ready then falls until the
// result is taken.
// Synchronous reset empties both registers, returns to idle with an empty
// symbol buffer and loads the reset dot length and debounce minimum.
// Configuration writes (cfg_we, cfg_index, cfg_wdata) take effect at once and
// are meant for idle periods; writing the dot length reloads the estimate.
`default_nettype none

module morse_key_decoder_core
  import mkd_pkg::*;
#(
  parameter int MAX_SYMBOLS = DEF_MAX_SYMBOLS,
  parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output      logic                 in_ready,
  input  wire logic                 in_button_down,
  output      logic                 out_valid,
  input  wire logic                 out_ready,
  output      logic [KIND_W-1:0]    out_event_kind,
  output      logic [LETTER_W-1:0]  out_letter_index,
  output      logic [DOT_W-1:0]     out_dot_estimate_now,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [DOT_W-1:0]     cfg_wdata
);

  localparam int CMP_W = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;
  localparam int ADP_W = ((COUNT_WIDTH > 15) ? COUNT_WIDTH : 15) + 1;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_PRESSED,
    PH_GAP
  } phase_t;

  phase_t                  phase_r, phase_nxt;
  logic [COUNT_WIDTH-1:0]  press_r, press_nxt;
  logic [COUNT_WIDTH-1:0]  gap_r, gap_nxt;
  logic [COUNT_WIDTH-1:0]  last_press_r, last_press_nxt;
  logic [DOT_W-1:0]        dot_r, dot_nxt;
  logic [DOT_W-1:0]        min_press_r, min_press_nxt;
  logic [MAX_SYMBOLS-1:0]  pattern_r, pattern_nxt;
  logic [SCOUNT_W-1:0]     count_r, count_nxt;
  logic                    overflow_r, overflow_nxt;
  logic                    pending_r, pending_nxt;

  logic                    s1_valid_r;
  logic                    s1_down_r;
  logic                    out_valid_r;
  logic [KIND_W-1:0]       out_kind_r;
  logic [LETTER_W-1:0]     out_letter_r;
  logic [DOT_W-1:0]        out_dot_r;

  logic                    advance;
  logic                    proc;
  logic                    emit;
  ev_kind_t                emit_kind;
  logic [LETTER_W-1:0]     emit_letter;

  logic [COUNT_WIDTH-1:0]  press_inc;
  logic [COUNT_WIDTH-1:0]  gap_inc;
  logic [DOT_W:0]          dot2;
  logic [14:0]             dot5;
  logic [14:0]             dot7;
  logic [15:0]             dot12;
  logic [ADP_W-1:0]        adapt_sum;
  logic [ADP_W-1:0]        adapt_avg;
  logic [DOT_W-1:0]        adapt_dot;
  logic                    is_dash;
  mkd_match_t              match;

  assign advance  = !out_valid_r || out_ready;
  assign proc     = s1_valid_r && advance;
  assign in_ready = !s1_valid_r || advance;

  assign press_inc = (&press_r) ? press_r : press_r + 1'b1;
  assign gap_inc   = (&gap_r) ? gap_r : gap_r + 1'b1;

  assign dot2  = {dot_r, 1'b0};
  assign dot5  = 15'({dot_r, 2'b00}) + 15'(dot_r);
  assign dot7  = 15'({dot_r, 3'b000}) - 15'(dot_r);
  assign dot12 = 16'({dot_r, 3'b000}) + 16'({dot_r, 2'b00});

  assign adapt_sum = ADP_W'(dot7) + ADP_W'(last_press_r);
  assign adapt_avg = adapt_sum >> 3;

  always_comb begin
    if (|adapt_avg[ADP_W-1:DOT_W]) begin
      adapt_dot = '1;
    end else if (adapt_avg[DOT_W-1:0] == '0) begin
      adapt_dot = DOT_W'(1);
    end else begin
      adapt_dot = adapt_avg[DOT_W-1:0];
    end
  end

  assign is_dash = CMP_W'(press_r) >= CMP_W'(dot2);

  mkd_letter_match #(
    .MAX_SYMBOLS (MAX_SYMBOLS)
  ) u_match (
    .pattern      (pattern_r),
    .symbol_count (count_r),
    .overflowed   (overflow_r),
    .result       (match)
  );

  always_comb begin
    phase_nxt      = phase_r;
    press_nxt      = press_r;
    gap_nxt        = gap_r;
    last_press_nxt = last_press_r;
    dot_nxt        = dot_r;
    min_press_nxt  = min_press_r;
    pattern_nxt    = pattern_r;
    count_nxt      = count_r;
    overflow_nxt   = overflow_r;
    pending_nxt    = pending_r;
    emit           = 1'b0;
    emit_kind      = EV_DOT;
    emit_letter    = '0;

    if (proc) begin
      if (phase_r == PH_PRESSED) begin
        if (s1_down_r) begin
          press_nxt = press_inc;
        end else if (CMP_W'(press_r) < CMP_W'(min_press_r)) begin
          // Bounce: drop the press and leave the unfinished letter waiting.
          phase_nxt = PH_IDLE;
        end else begin
          last_press_nxt = press_r;
          if (32'(count_r) < 32'(MAX_SYMBOLS)) begin
            for (int i = 0; i < MAX_SYMBOLS; i++) begin
              if (32'(count_r) == i) begin
                pattern_nxt[i] = pattern_r[i] | is_dash;
              end
            end
          end else begin
            overflow_nxt = 1'b1;
          end
          if (!(&count_r)) begin
            count_nxt = count_r + 1'b1;
          end
          phase_nxt   = PH_GAP;
          gap_nxt     = '0;
          pending_nxt = 1'b0;
          emit        = 1'b1;
          emit_kind   = is_dash ? EV_DASH : EV_DOT;
        end
      end else if (s1_down_r) begin
        // The first press of a letter tunes the dot estimate once the second starts.
        if (phase_r == PH_GAP && !pending_r && count_r == SCOUNT_W'(1)) begin
          dot_nxt = adapt_dot;
        end
        pending_nxt = 1'b0;
        phase_nxt   = PH_PRESSED;
        press_nxt   = COUNT_WIDTH'(1);
      end else if (phase_r == PH_GAP) begin
        gap_nxt = gap_inc;
        if (!pending_r) begin
          if (CMP_W'(gap_inc) > CMP_W'(dot5)) begin
            emit         = 1'b1;
            emit_kind    = match.hit ? EV_LETTER : EV_UNKNOWN;
            emit_letter  = match.hit ? match.index : '0;
            pattern_nxt  = '0;
            count_nxt    = '0;
            overflow_nxt = 1'b0;
            pending_nxt  = 1'b1;
          end
        end else if (CMP_W'(gap_inc) > CMP_W'(dot12)) begin
          emit        = 1'b1;
          emit_kind   = EV_SPACE;
          pending_nxt = 1'b0;
          phase_nxt   = PH_IDLE;
        end
      end
    end

    if (cfg_we) begin
      case (cfg_index)
        CFG_INITIAL_DOT: dot_nxt = (cfg_wdata == '0) ? DOT_W'(1) : cfg_wdata;
        CFG_MIN_PRESS:   min_press_nxt = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      press_r      <= '0;
      gap_r        <= '0;
      last_press_r <= '0;
      dot_r        <= DOT_RESET;
      min_press_r  <= MIN_PRESS_RESET;
      pattern_r    <= '0;
      count_r      <= '0;
      overflow_r   <= 1'b0;
      pending_r    <= 1'b0;
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      press_r      <= press_nxt;
      gap_r        <= gap_nxt;
      last_press_r <= last_press_nxt;
      dot_r        <= dot_nxt;
      min_press_r  <= min_press_nxt;
      pattern_r    <= pattern_nxt;
      count_r      <= count_nxt;
      overflow_r   <= overflow_nxt;
      pending_r    <= pending_nxt;
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= proc && emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_down_r <= in_button_down;
    end
    if (proc && emit) begin
      out_kind_r   <= emit_kind;
      out_letter_r <= emit_letter;
      out_dot_r    <= dot_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_event_kind       = out_kind_r;
  assign out_letter_index     = out_letter_r;
  assign out_dot_estimate_now = out_dot_r;

  a_dot_nonzero : assert property (@(posedge clk) disable iff (!rst_n)
    dot_r != '0)
    else $error("dot estimate reached zero");

  a_letter_only : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_kind_r != EV_LETTER |-> out_letter_r == '0)
    else $error("letter index set on a word that is not a letter");

  a_pending_empty : assert property (@(posedge clk) disable iff (!rst_n)
    pending_r |-> count_r == '0 && pattern_r == '0 && !overflow_r)
    else $error("symbol buffer not empty after a letter was decoded");

  a_press_counted : assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_PRESSED |-> press_r != '0)
    else $error("press counter empty during a press");

  a_overflow_count : assert property (@(posedge clk) disable iff (!rst_n)
    overflow_r |-> 32'(count_r) >= 32'(MAX_SYMBOLS))
    else $error("overflow flag set with room left in the buffer");

endmodule

`default_nettype wire
